// File: hdl/char_lcd_nibble_write_controller_assert.svh
// assertion helpers used by the sequencer module
`ifndef CHAR_LCD_NIBBLE_WRITE_CONTROLLER_ASSERT_SVH
`define CHAR_LCD_NIBBLE_WRITE_CONTROLLER_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication, held off during reset
`define LCDNW_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// next-cycle implication, held off during reset
`define LCDNW_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`else

`define LCDNW_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define LCDNW_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// File: hdl/lcdnw_pkg.sv
package lcdnw_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_POWER_UP_WAIT  = 3'd0;
    localparam logic [2:0] CFG_ENABLE_TICKS   = 3'd1;
    localparam logic [2:0] CFG_NIBBLE_GAP     = 3'd2;
    localparam logic [2:0] CFG_DATA_SETTLE    = 3'd3;
    localparam logic [2:0] CFG_COMMAND_SETTLE = 3'd4;

    // configuration reset values
    localparam logic [11:0] RST_POWER_UP_WAIT  = 12'd160;
    localparam logic [7:0]  RST_ENABLE_TICKS   = 8'd1;
    localparam logic [7:0]  RST_NIBBLE_GAP     = 8'd10;
    localparam logic [7:0]  RST_DATA_SETTLE    = 8'd20;
    localparam logic [7:0]  RST_COMMAND_SETTLE = 8'd0;

    // beat operation codes and register select codes
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_WRITE   = 1'b1;
    localparam logic RS_COMMAND = 1'b0;
    localparam logic RS_CHAR    = 1'b1;

    // power-up sequence: four wake-up nibbles, then four command bytes
    localparam logic [3:0] INIT_STEPS        = 4'd8;
    localparam logic [3:0] INIT_NIBBLE_STEPS = 4'd4;

    // most state advances that one tick can chain (enable fall, gap end, wait end)
    localparam int CHAIN_DEPTH = 3;

    typedef struct packed {
        logic [11:0] power_up_wait;
        logic [7:0]  enable_ticks;
        logic [7:0]  nibble_gap;
        logic [7:0]  data_settle;
        logic [7:0]  command_settle;
    } cfg_t;

    typedef struct packed {
        logic       operation;
        logic [7:0] value;
        logic       register_select;
    } item_t;

    typedef struct packed {
        logic       lcd_rs;
        logic       lcd_enable;
        logic [3:0] lcd_data;
        logic       busy_res;
        logic       rejected;
    } result_t;

    // byte sent at each power-up step
    function automatic logic [7:0] init_value(logic [2:0] step);
        logic [7:0] v;
        begin
            unique case (step)
                3'd0:    v = 8'h03;
                3'd1:    v = 8'h03;
                3'd2:    v = 8'h03;
                3'd3:    v = 8'h02;
                3'd4:    v = 8'h28;
                3'd5:    v = 8'h08;
                3'd6:    v = 8'h01;
                default: v = 8'h0C;
            endcase
            return v;
        end
    endfunction

    // fixed wait after each power-up step
    function automatic logic [5:0] init_wait(logic [2:0] step);
        logic [5:0] w;
        begin
            unique case (step)
                3'd0:    w = 6'd50;
                3'd1:    w = 6'd50;
                3'd2:    w = 6'd2;
                3'd3:    w = 6'd20;
                3'd4:    w = 6'd20;
                3'd5:    w = 6'd0;
                3'd6:    w = 6'd20;
                default: w = 6'd0;
            endcase
            return w;
        end
    endfunction

endpackage

// File: hdl/char_lcd_nibble_write_controller.sv
// channel   | ports                                             | direction
// ----------+---------------------------------------------------+----------
// request   | s_valid s_ready s_operation s_value               | in
//           | s_register_select                                 |
// pins      | m_valid m_ready m_lcd_rs m_lcd_enable m_lcd_data  | out
//           | m_busy_res m_rejected                             |
// config    | cfg_we cfg_index cfg_wdata                        | in
//
// one beat per cycle in and out unless m_ready stalls the result register; a result
// is offered on m_valid once its beat has passed the input register and the result register
// a tick or request updates the sequencer in the cycle it leaves the input
// register, so back-to-back beats see each other's state
// synchronous active-low reset starts the power-up wait with pins low
// a stalled result register holds the input register, which then drops s_ready
module char_lcd_nibble_write_controller (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [7:0]  s_value,
    input  logic        s_register_select,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_lcd_rs,
    output logic        m_lcd_enable,
    output logic [3:0]  m_lcd_data,
    output logic        m_busy_res,
    output logic        m_rejected
);

    lcdnw_pkg::cfg_t    cfg;
    lcdnw_pkg::item_t   item_reg;
    lcdnw_pkg::result_t result;
    lcdnw_pkg::result_t result_reg;
    logic               in_valid_reg;
    logic               in_valid_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               step;

    // pipeline handshake
    assign step    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (step) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input and result payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.operation       <= s_operation;
            item_reg.value           <= s_value;
            item_reg.register_select <= s_register_select;
        end
        if (step) begin
            result_reg <= result;
        end
    end

    lcdnw_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg_o     (cfg)
    );

    lcdnw_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_i   (step),
        .item_i   (item_reg),
        .cfg_i    (cfg),
        .result_o (result)
    );

    assign m_valid      = out_valid_reg;
    assign m_lcd_rs     = result_reg.lcd_rs;
    assign m_lcd_enable = result_reg.lcd_enable;
    assign m_lcd_data   = result_reg.lcd_data;
    assign m_busy_res   = result_reg.busy_res;
    assign m_rejected   = result_reg.rejected;

endmodule

// File: hdl/lcdnw_cfg.sv
module lcdnw_cfg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [11:0]        cfg_wdata,
    output lcdnw_pkg::cfg_t    cfg_o
);

    lcdnw_pkg::cfg_t cfg_reg;
    lcdnw_pkg::cfg_t cfg_next;

    // register decode
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                lcdnw_pkg::CFG_POWER_UP_WAIT:  cfg_next.power_up_wait  = cfg_wdata;
                lcdnw_pkg::CFG_ENABLE_TICKS:   cfg_next.enable_ticks   = cfg_wdata[7:0];
                lcdnw_pkg::CFG_NIBBLE_GAP:     cfg_next.nibble_gap     = cfg_wdata[7:0];
                lcdnw_pkg::CFG_DATA_SETTLE:    cfg_next.data_settle    = cfg_wdata[7:0];
                lcdnw_pkg::CFG_COMMAND_SETTLE: cfg_next.command_settle = cfg_wdata[7:0];
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.power_up_wait  <= lcdnw_pkg::RST_POWER_UP_WAIT;
            cfg_reg.enable_ticks   <= lcdnw_pkg::RST_ENABLE_TICKS;
            cfg_reg.nibble_gap     <= lcdnw_pkg::RST_NIBBLE_GAP;
            cfg_reg.data_settle    <= lcdnw_pkg::RST_DATA_SETTLE;
            cfg_reg.command_settle <= lcdnw_pkg::RST_COMMAND_SETTLE;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_o = cfg_reg;

endmodule

// File: hdl/lcdnw_seq.sv
`include "char_lcd_nibble_write_controller_assert.svh"

module lcdnw_seq (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step_i,
    input  lcdnw_pkg::item_t    item_i,
    input  lcdnw_pkg::cfg_t     cfg_i,
    output lcdnw_pkg::result_t  result_o
);

    typedef enum logic [2:0] {
        PH_POWER,
        PH_SETUP,
        PH_HIGH,
        PH_GAP,
        PH_WAIT,
        PH_IDLE
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [11:0] wait_count;
        logic [3:0]  init_step;
        logic [7:0]  held_byte;
        logic        held_select;
        logic        low_nibble_next;
        logic        pin_rs;
        logic        pin_en;
        logic [3:0]  pin_data;
    } seq_t;

    seq_t state_reg;
    seq_t state_next;
    logic rejected;

    // enable setup and high time, zero counts as one
    function automatic logic [7:0] en_time(lcdnw_pkg::cfg_t c);
        return (c.enable_ticks == 8'd0) ? 8'd1 : c.enable_ticks;
    endfunction

    // drive a nibble and rs, start the setup interval
    function automatic seq_t start_nibble(seq_t s, logic [3:0] nib, lcdnw_pkg::cfg_t c);
        seq_t r;
        begin
            r            = s;
            r.pin_data   = nib;
            r.pin_rs     = s.held_select;
            r.phase      = PH_SETUP;
            r.wait_count = {4'd0, en_time(c)};
            return r;
        end
    endfunction

    // load the current power-up step; wake-up steps send only the low nibble
    function automatic seq_t start_init_entry(seq_t s, lcdnw_pkg::cfg_t c);
        seq_t r;
        begin
            r             = s;
            r.held_byte   = lcdnw_pkg::init_value(s.init_step[2:0]);
            r.held_select = 1'b0;
            if (s.init_step < lcdnw_pkg::INIT_NIBBLE_STEPS) begin
                r.low_nibble_next = 1'b0;
                r = start_nibble(r, r.held_byte[3:0], c);
            end else begin
                r.low_nibble_next = 1'b1;
                r = start_nibble(r, r.held_byte[7:4], c);
            end
            return r;
        end
    endfunction

    // one step of the sequencer once the current interval has run out
    function automatic seq_t advance(seq_t s, lcdnw_pkg::cfg_t c);
        seq_t       r;
        logic [7:0] settle;
        begin
            r      = s;
            settle = 8'd0;
            unique case (s.phase)
                PH_POWER: begin
                    r.init_step = 4'd0;
                    r = start_init_entry(r, c);
                end
                PH_SETUP: begin
                    r.pin_en     = 1'b1;
                    r.phase      = PH_HIGH;
                    r.wait_count = {4'd0, en_time(c)};
                end
                PH_HIGH: begin
                    r.pin_en     = 1'b0;
                    r.phase      = PH_GAP;
                    r.wait_count = {4'd0, c.nibble_gap};
                end
                PH_GAP: begin
                    r.pin_data = 4'd0;
                    if (s.low_nibble_next) begin
                        r.low_nibble_next = 1'b0;
                        r = start_nibble(r, r.held_byte[3:0], c);
                    end else begin
                        r.phase = PH_WAIT;
                        if (s.init_step < lcdnw_pkg::INIT_STEPS) begin
                            if (s.init_step >= lcdnw_pkg::INIT_NIBBLE_STEPS) begin
                                settle = c.command_settle;
                            end
                            r.wait_count = 12'(settle)
                                + 12'(lcdnw_pkg::init_wait(s.init_step[2:0]));
                        end else begin
                            settle = s.held_select ? c.data_settle : c.command_settle;
                            r.wait_count = {4'd0, settle};
                        end
                    end
                end
                PH_WAIT: begin
                    r.phase      = PH_IDLE;
                    r.wait_count = 12'd0;
                    if (s.init_step < lcdnw_pkg::INIT_STEPS) begin
                        r.init_step = s.init_step + 4'd1;
                        if (r.init_step < lcdnw_pkg::INIT_STEPS) begin
                            r = start_init_entry(r, c);
                        end
                    end
                end
                default: begin
                    r.phase = PH_IDLE;
                end
            endcase
            return r;
        end
    endfunction

    // next state for the beat in the input register
    always_comb begin
        state_next = state_reg;
        rejected   = 1'b0;
        if (item_i.operation == lcdnw_pkg::OP_WRITE) begin
            if (state_reg.phase == PH_IDLE) begin
                state_next.held_byte       = item_i.value;
                state_next.held_select     = item_i.register_select;
                state_next.low_nibble_next = 1'b1;
                state_next = start_nibble(state_next, item_i.value[7:4], cfg_i);
            end else begin
                rejected = 1'b1;
            end
        end else if (state_reg.phase == PH_POWER) begin
            // power-up count compared live against the register
            if (state_reg.wait_count < cfg_i.power_up_wait) begin
                state_next.wait_count = state_reg.wait_count + 12'd1;
            end
            if (state_next.wait_count >= cfg_i.power_up_wait) begin
                state_next = advance(state_next, cfg_i);
            end
        end else if (state_reg.phase != PH_IDLE) begin
            if (state_reg.wait_count != 12'd0) begin
                state_next.wait_count = state_reg.wait_count - 12'd1;
            end
            // zero-length intervals fall through within the same tick
            for (int k = 0; k < lcdnw_pkg::CHAIN_DEPTH; k++) begin
                if (state_next.phase != PH_IDLE && state_next.wait_count == 12'd0) begin
                    state_next = advance(state_next, cfg_i);
                end
            end
        end
    end

    // pin levels after this beat
    always_comb begin
        result_o.lcd_rs     = state_next.pin_rs;
        result_o.lcd_enable = state_next.pin_en;
        result_o.lcd_data   = state_next.pin_data;
        result_o.busy_res   = (state_next.phase != PH_IDLE);
        result_o.rejected   = rejected;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase           <= PH_POWER;
            state_reg.wait_count      <= 12'd0;
            state_reg.init_step       <= 4'd0;
            state_reg.held_byte       <= 8'd0;
            state_reg.held_select     <= 1'b0;
            state_reg.low_nibble_next <= 1'b0;
            state_reg.pin_rs          <= 1'b0;
            state_reg.pin_en          <= 1'b0;
            state_reg.pin_data        <= 4'd0;
        end else if (step_i) begin
            state_reg <= state_next;
        end
    end

    // enable is high exactly during the enable-high interval
    `LCDNW_ASSERT_IMP(a_en_phase, aclk, aresetn, 1'b1,
        state_reg.pin_en == (state_reg.phase == PH_HIGH))

    // idle leaves the strobe low and the data lines cleared
    `LCDNW_ASSERT_IMP(a_idle_pins, aclk, aresetn, state_reg.phase == PH_IDLE,
        !state_reg.pin_en && state_reg.pin_data == 4'd0)

    // a running interval never rests at a zero count
    `LCDNW_ASSERT_IMP(a_wait_live, aclk, aresetn,
        state_reg.phase != PH_POWER && state_reg.phase != PH_IDLE,
        state_reg.wait_count != 12'd0)

    // a dropped request leaves the sequencer untouched
    `LCDNW_ASSERT_NXT(a_reject_hold, aclk, aresetn,
        step_i && item_i.operation == lcdnw_pkg::OP_WRITE && state_reg.phase != PH_IDLE,
        $stable(state_reg))

endmodule
